@@ hdl/glos_pkg.sv @@
// Package for the grid line-of-sight tracer: sizes, codes, types and helpers.
// Depends on nothing; every other file of the block but glos_map_ram uses it.
package glos_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;

    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    localparam int CELL_W    = 3;
    localparam int COORD_W   = 16;
    localparam int BND_W     = COORD_W + 1;
    localparam int SIZE_W    = 9;
    localparam int RANGE_W   = 10;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 8;
    localparam int ERR_W     = 20;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SIGHT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TRACE = 2'd2;

    localparam logic [CELL_W-1:0] CELL_GROUND   = 3'd0;
    localparam logic [CELL_W-1:0] CELL_WALL     = 3'd3;
    localparam logic [CELL_W-1:0] CELL_MOUNTAIN = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 8'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_INIT,
        ST_ERR,
        ST_ADDR,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Effective map size, already clamped to the storage size.
    typedef struct packed {
        logic [BND_W-1:0] cols;
        logic [BND_W-1:0] rows;
    } bounds_t;

    // One access to the terrain memory.
    typedef struct packed {
        logic              en;
        logic              we;
        logic [MAP_AW-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } mem_req_t;

    function automatic logic cell_in_map(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input bounds_t b);
        logic x_ok;
        logic y_ok;
        x_ok = !x[COORD_W-1] && ({1'b0, x} < b.cols);
        y_ok = !y[COORD_W-1] && ({1'b0, y} < b.rows);
        return x_ok && y_ok;
    endfunction

    function automatic logic [MAP_AW-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
        logic [MAP_AW-1:0] row_base;
        row_base = MAP_AW'(y[ROW_W-1:0]) * MAP_AW'(MAX_COLUMNS);
        return row_base + MAP_AW'(x[COL_W-1:0]);
    endfunction

endpackage

@@ hdl/glos_ifs.sv @@
// Channel interfaces of the grid line-of-sight tracer: request, result, configuration.
// Depends on glos_pkg for field widths.
interface glos_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [glos_pkg::REQ_W-1:0]              req_type;
    logic signed [glos_pkg::COORD_W-1:0]     from_x;
    logic signed [glos_pkg::COORD_W-1:0]     from_y;
    logic signed [glos_pkg::COORD_W-1:0]     to_x;
    logic signed [glos_pkg::COORD_W-1:0]     to_y;
    logic [glos_pkg::CELL_W-1:0]             cell_code;
    logic [glos_pkg::RANGE_W-1:0]            range_limit;

    modport source (output valid, req_type, from_x, from_y, to_x, to_y, cell_code,
                    range_limit, input ready);
    modport sink (input valid, req_type, from_x, from_y, to_x, to_y, cell_code,
                  range_limit, output ready);
endinterface

interface glos_res_if;
    logic                                valid;
    logic                                ready;
    logic                                clear_sight;
    logic                                hit_found;
    logic signed [glos_pkg::COORD_W-1:0] hit_x;
    logic signed [glos_pkg::COORD_W-1:0] hit_y;

    modport source (output valid, clear_sight, hit_found, hit_x, hit_y, input ready);
    modport sink (input valid, clear_sight, hit_found, hit_x, hit_y, output ready);
endinterface

interface glos_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [glos_pkg::CFG_IDX_W-1:0]     index;
    logic [glos_pkg::SIZE_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/glos_map_ram.sv @@
// Single-port synchronous RAM holding the terrain cells, with a registered read port.
// Generic; no package dependency.
module glos_map_ram #(
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 3,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/glos_engine.sv @@
// Request sequencer: cell writes and the Bresenham walker for both query kinds,
// with the result register. Depends on glos_pkg and glos_ifs.
module glos_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  glos_pkg::bounds_t  bounds,
    output glos_pkg::mem_req_t mem_req,
    input  logic [glos_pkg::CELL_W-1:0] mem_rdata,
    glos_req_if.sink           req,
    glos_res_if.source         res
);
    import glos_pkg::*;

    state_t state_reg, state_next;

    logic [REQ_W-1:0]          op_reg, op_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [COORD_W-1:0] tx_reg, tx_next;
    logic signed [COORD_W-1:0] ty_reg, ty_next;
    logic [CELL_W-1:0]         code_reg, code_next;
    logic [RANGE_W-1:0]        range_reg, range_next;
    logic [RANGE_W-1:0]        steps_reg, steps_next;
    logic signed [ERR_W-1:0]   dx_reg, dx_next;
    logic signed [ERR_W-1:0]   dy_reg, dy_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic                      sx_neg_reg, sx_neg_next;
    logic                      sy_neg_reg, sy_neg_next;
    logic                      first_reg, first_next;
    logic                      inmap_reg, inmap_next;
    logic                      res_clear_reg, res_clear_next;
    logic                      res_hit_reg, res_hit_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_clear_reg, out_clear_next;
    logic                      out_hit_reg, out_hit_next;
    logic signed [COORD_W-1:0] out_x_reg, out_x_next;
    logic signed [COORD_W-1:0] out_y_reg, out_y_next;

    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic signed [ERR_W-1:0]   diff_x_w;
    logic signed [ERR_W-1:0]   diff_y_w;
    logic signed [ERR_W:0]     e2;
    logic                      move_x;
    logic                      move_y;
    logic                      step_fail;
    logic                      at_target;
    logic                      blocked;
    logic signed [ERR_W-1:0]   err_step;
    logic signed [COORD_W-1:0] x_step;
    logic signed [COORD_W-1:0] y_step;
    logic                      accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = enable && (state_reg == ST_IDLE);

    // Walker arithmetic, evaluated from the registered walker state.
    always_comb
    begin
        diff_x    = {tx_reg[COORD_W-1], tx_reg} - {x_reg[COORD_W-1], x_reg};
        diff_y    = {ty_reg[COORD_W-1], ty_reg} - {y_reg[COORD_W-1], y_reg};
        diff_x_w  = {{(ERR_W-COORD_W-1){diff_x[COORD_W]}}, diff_x};
        diff_y_w  = {{(ERR_W-COORD_W-1){diff_y[COORD_W]}}, diff_y};
        e2        = {err_reg, 1'b0};
        move_x    = e2 >= $signed({dy_reg[ERR_W-1], dy_reg});
        move_y    = e2 <= $signed({dx_reg[ERR_W-1], dx_reg});
        step_fail = (move_x && (x_reg == tx_reg)) || (move_y && (y_reg == ty_reg));
        err_step  = err_reg + (move_x ? dy_reg : '0) + (move_y ? dx_reg : '0);
        x_step    = move_x ? (sx_neg_reg ? x_reg - 16'sd1 : x_reg + 16'sd1) : x_reg;
        y_step    = move_y ? (sy_neg_reg ? y_reg - 16'sd1 : y_reg + 16'sd1) : y_reg;
        at_target = (x_reg == tx_reg) && (y_reg == ty_reg);
        blocked   = !inmap_reg || (mem_rdata == CELL_WALL) || (mem_rdata == CELL_MOUNTAIN);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        code_next      = code_reg;
        range_next     = range_reg;
        steps_next     = steps_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        err_next       = err_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        first_next     = first_reg;
        inmap_next     = inmap_reg;
        res_clear_next = res_clear_reg;
        res_hit_next   = res_hit_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_clear_next = out_clear_reg;
        out_hit_next   = out_hit_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.req_type;
                    x_next         = req.from_x;
                    y_next         = req.from_y;
                    tx_next        = req.to_x;
                    ty_next        = req.to_y;
                    code_next      = req.cell_code;
                    range_next     = req.range_limit;
                    steps_next     = '0;
                    first_next     = 1'b1;
                    res_clear_next = 1'b0;
                    res_hit_next   = 1'b0;
                    priority if (req.req_type == REQ_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (req.req_type == REQ_SIGHT || req.req_type == REQ_TRACE)
                    begin
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_WRITE:
            begin
                mem_req.en    = cell_in_map(x_reg, y_reg, bounds);
                mem_req.we    = 1'b1;
                mem_req.addr  = cell_addr(x_reg, y_reg);
                mem_req.wdata = code_reg;
                state_next    = ST_DONE;
            end

            ST_INIT:
            begin
                dx_next     = diff_x_w[ERR_W-1] ? -diff_x_w : diff_x_w;
                dy_next     = diff_y_w[ERR_W-1] ? diff_y_w : -diff_y_w;
                sx_neg_next = !(x_reg < tx_reg);
                sy_neg_next = !(y_reg < ty_reg);
                state_next  = ST_ERR;
            end

            ST_ERR:
            begin
                err_next   = dx_reg + dy_reg;
                state_next = ST_CHECK;
            end

            ST_ADDR:
            begin
                inmap_next    = cell_in_map(x_reg, y_reg, bounds);
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b0;
                mem_req.addr  = cell_addr(x_reg, y_reg);
                mem_req.wdata = CELL_GROUND;
                state_next    = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (op_reg == REQ_SIGHT)
                begin
                    priority if (at_target)
                    begin
                        res_clear_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else if (!first_reg && blocked)
                    begin
                        res_clear_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else if (step_fail)
                    begin
                        res_clear_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        x_next     = x_step;
                        y_next     = y_step;
                        err_next   = err_step;
                        first_next = 1'b0;
                        state_next = ST_ADDR;
                    end
                end
                else
                begin
                    // Projectile: the cell just entered is tested before the range check.
                    priority if (!first_reg && blocked)
                    begin
                        res_hit_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (steps_reg == range_reg)
                    begin
                        res_hit_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else if (at_target)
                    begin
                        res_hit_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (step_fail)
                    begin
                        res_hit_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        x_next     = x_step;
                        y_next     = y_step;
                        err_next   = err_step;
                        steps_next = steps_reg + 1'b1;
                        first_next = 1'b0;
                        state_next = ST_ADDR;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_clear_next = res_clear_reg;
                    out_hit_next   = res_hit_reg;
                    out_x_next     = res_hit_reg ? x_reg : '0;
                    out_y_next     = res_hit_reg ? y_reg : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        code_reg      <= code_next;
        range_reg     <= range_next;
        steps_reg     <= steps_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        err_reg       <= err_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        first_reg     <= first_next;
        inmap_reg     <= inmap_next;
        res_clear_reg <= res_clear_next;
        res_hit_reg   <= res_hit_next;
        out_clear_reg <= out_clear_next;
        out_hit_reg   <= out_hit_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.clear_sight = out_clear_reg;
    assign res.hit_found   = out_hit_reg;
    assign res.hit_x       = out_x_reg;
    assign res.hit_y       = out_y_reg;

endmodule

@@ hdl/grid_line_of_sight_tracer.sv @@
// Top level of the grid line-of-sight tracer: configuration registers, the
// post-reset clearing sweep and the terrain memory. Depends on glos_pkg,
// glos_ifs, glos_map_ram and glos_engine.
//
// The block keeps a terrain map of 3-bit cell codes in one single-port RAM of
// MAX_COLUMNS x MAX_ROWS entries and answers every request transaction with
// exactly one result transaction. After reset a clearing sweep writes ground
// into every entry, one per cycle, and requests are held off until it has
// finished; configuration writes are taken throughout. A cell write passes
// from acceptance through the write state to completion, where the result is
// offered. A line-of-sight or projectile query passes from acceptance through
// the two set-up steps to a first test at the start cell; then, for every cell
// the Bresenham walk enters, one step issues the memory read and one tests the
// returned cell and advances, and completion offers the result.
// One request is worked on at a time; the result sits in an output register,
// so a new request can be taken while the previous result waits. The map size
// registers should only be written while no request is outstanding.
module grid_line_of_sight_tracer (
    input  logic       clk,
    input  logic       rst_n,
    glos_req_if.sink   req,
    glos_res_if.source res,
    glos_cfg_if.sink   cfg
);
    import glos_pkg::*;

    logic [SIZE_W-1:0] map_width_reg;
    logic [SIZE_W-1:0] map_height_reg;
    logic              clr_busy_reg, clr_busy_next;
    logic [MAP_AW-1:0] clr_addr_reg, clr_addr_next;
    bounds_t           bounds;
    mem_req_t          eng_req;
    mem_req_t          ram_req;
    logic [CELL_W-1:0] ram_rdata;

    // Configuration writes are always accepted; unknown indices are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= SIZE_RESET;
            map_height_reg <= SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_MAP_WIDTH)
            begin
                map_width_reg <= cfg.data;
            end
            if (cfg.index == CFG_MAP_HEIGHT)
            begin
                map_height_reg <= cfg.data;
            end
        end
    end

    // A size above the storage acts as the storage size; zero leaves no cell in bounds.
    always_comb
    begin
        bounds.cols = (BND_W'(map_width_reg) > BND_W'(MAX_COLUMNS)) ?
                      BND_W'(MAX_COLUMNS) : BND_W'(map_width_reg);
        bounds.rows = (BND_W'(map_height_reg) > BND_W'(MAX_ROWS)) ?
                      BND_W'(MAX_ROWS) : BND_W'(map_height_reg);
    end

    // Clearing sweep: writes ground into every entry once after reset.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == MAP_AW'(MAP_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // The sweep owns the memory port until it finishes; the engine is idle then.
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = clr_addr_reg;
            ram_req.wdata = CELL_GROUND;
        end
        else
        begin
            ram_req = eng_req;
        end
    end

    glos_map_ram #(
        .DEPTH  (MAP_DEPTH),
        .DATA_W (CELL_W)
    ) u_map_ram (
        .clk   (clk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    glos_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (!clr_busy_reg),
        .bounds    (bounds),
        .mem_req   (eng_req),
        .mem_rdata (ram_rdata),
        .req       (req),
        .res       (res)
    );

endmodule
